// File: hw/rtl/crlf_line_framer_macros.svh
// assertion macros used by the crlf line framer rtl
`ifndef CRLF_LINE_FRAMER_MACROS_SVH
`define CRLF_LINE_FRAMER_MACROS_SVH

// checked on every clock edge outside of reset
`define CLF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define CLF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/clf_pkg.sv
// shared types, constants and helpers of the crlf line framer
package clf_pkg;

  localparam int LINE_CAPACITY_DEF = 32;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  localparam int TEXT_W    = 56;
  localparam int KW_LEN_W  = 3;
  localparam int LEN_OUT_W = 5;
  localparam int KW_BYTES  = 7;

  // "Arrived", first character in the low byte
  localparam logic [TEXT_W-1:0]   KW_RESET_TEXT = 56'h64_6576_6972_7241;
  localparam logic [KW_LEN_W-1:0] KW_RESET_LEN  = 3'd7;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TEXT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE2,
    ST_READ,
    ST_LOAD,
    ST_EMPTY
  } fr_state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // keyword byte k of the packed text; no byte past the seventh
  function automatic logic [7:0] kw_byte(input logic [TEXT_W-1:0] text,
                                         input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = text[7:0];
      3'd1:    b = text[15:8];
      3'd2:    b = text[23:16];
      3'd3:    b = text[31:24];
      3'd4:    b = text[39:32];
      3'd5:    b = text[47:40];
      3'd6:    b = text[55:48];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/clf_store.sv
// line store: one write port, one registered read port
module clf_store import clf_pkg::*; #(
  parameter int DEPTH = LINE_CAPACITY_DEF,
  parameter int AW    = $clog2(LINE_CAPACITY_DEF)
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/clf_ctrl.sv
// framing sequencer: byte parsing, store writes, line readout and output register
`include "crlf_line_framer_macros.svh"

module clf_ctrl import clf_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
  parameter int AW            = $clog2(LINE_CAPACITY_DEF)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  output logic                 line_valid,
  input  logic                 line_stall,
  output logic [7:0]           line_byte,
  output logic                 last_of_line,
  output logic [LEN_OUT_W-1:0] line_length,
  output logic                 keyword_hit,
  output logic                 empty_line,
  input  logic [TEXT_W-1:0]    match_text,
  input  logic [KW_LEN_W-1:0]  match_length,
  output mem_ctl_t             mem_ctl,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  output logic [AW-1:0]        rd_addr,
  input  logic [7:0]           rd_data
);

  localparam logic [AW-1:0] FILL_MAX = AW'(LINE_CAPACITY - 1);

  fr_state_t state, state_next;
  logic [AW-1:0] fill, fill_next;
  logic          cr_pending, cr_pending_next;
  logic          discarding, discarding_next;
  logic [7:0]    pend_byte, pend_byte_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic          match_ok, match_ok_next;
  logic          line_valid_next;

  logic                 out_load;
  logic [7:0]           ld_byte;
  logic                 ld_last;
  logic [LEN_OUT_W-1:0] ld_len;
  logic                 ld_hit;
  logic                 ld_empty;

  logic        is_cr, is_lf, full, line_free, len_eq, byte_ok, is_last;
  logic [31:0] fill_w, idx_w;

  assign is_cr     = (rx_byte == BYTE_CR);
  assign is_lf     = (rx_byte == BYTE_LF);
  assign full      = (fill == FILL_MAX);
  assign line_free = !line_valid || !line_stall;
  assign fill_w    = 32'(fill);
  assign idx_w     = 32'(rd_idx);
  assign len_eq    = (fill_w == 32'(match_length));
  assign byte_ok   = (idx_w >= 32'(KW_BYTES)) ||
                     (rd_data == kw_byte(match_text, idx_w[2:0]));
  assign is_last   = (rd_idx == fill - AW'(1));
  assign rx_stall  = (state != ST_IDLE);
  assign rd_addr   = rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      cr_pending <= 1'b0;
      discarding <= 1'b0;
      line_valid <= 1'b0;
      rd_idx     <= '0;
      match_ok   <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      cr_pending <= cr_pending_next;
      discarding <= discarding_next;
      line_valid <= line_valid_next;
      rd_idx     <= rd_idx_next;
      match_ok   <= match_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte <= pend_byte_next;
    if (out_load) begin
      line_byte    <= ld_byte;
      last_of_line <= ld_last;
      line_length  <= ld_len;
      keyword_hit  <= ld_hit;
      empty_line   <= ld_empty;
    end
  end

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    cr_pending_next = cr_pending;
    discarding_next = discarding;
    pend_byte_next  = pend_byte;
    rd_idx_next     = rd_idx;
    match_ok_next   = match_ok;
    mem_ctl         = '0;
    wr_addr         = fill;
    wr_data         = rx_byte;
    out_load        = 1'b0;
    ld_byte         = rd_data;
    ld_last         = 1'b0;
    ld_len          = '0;
    ld_hit          = 1'b0;
    ld_empty        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (rx_valid) begin
          if (discarding) begin
            if (cr_pending && is_lf) begin
              fill_next       = '0;
              cr_pending_next = 1'b0;
              discarding_next = 1'b0;
            end else begin
              cr_pending_next = is_cr;
            end
          end else if (cr_pending && is_lf) begin
            cr_pending_next = 1'b0;
            if (fill == '0) begin
              state_next = ST_EMPTY;
            end else begin
              rd_idx_next   = '0;
              match_ok_next = 1'b1;
              state_next    = ST_READ;
            end
          end else if (cr_pending) begin
            // held cr becomes data, then the new byte is handled; a full store drops both and discards
            cr_pending_next = 1'b0;
            if (full) begin
              fill_next       = '0;
              discarding_next = 1'b1;
            end else begin
              mem_ctl.wr_en = 1'b1;
              wr_data       = BYTE_CR;
              fill_next     = fill + AW'(1);
              if (is_cr) begin
                cr_pending_next = 1'b1;
              end else begin
                pend_byte_next = rx_byte;
                state_next     = ST_STORE2;
              end
            end
          end else if (is_cr) begin
            cr_pending_next = 1'b1;
          end else if (!is_lf) begin
            if (full) begin
              fill_next       = '0;
              discarding_next = 1'b1;
            end else begin
              mem_ctl.wr_en = 1'b1;
              fill_next     = fill + AW'(1);
            end
          end
        end
      end
      ST_STORE2: begin
        if (full) begin
          fill_next       = '0;
          discarding_next = 1'b1;
        end else begin
          mem_ctl.wr_en = 1'b1;
          wr_data       = pend_byte;
          fill_next     = fill + AW'(1);
        end
        state_next = ST_IDLE;
      end
      ST_READ: begin
        mem_ctl.rd_en = 1'b1;
        state_next    = ST_LOAD;
      end
      ST_LOAD: begin
        if (line_free) begin
          out_load = 1'b1;
          ld_last  = is_last;
          if (is_last) begin
            ld_len     = fill_w[LEN_OUT_W-1:0];
            ld_hit     = len_eq && match_ok && byte_ok;
            fill_next  = '0;
            state_next = ST_IDLE;
          end else begin
            rd_idx_next   = rd_idx + AW'(1);
            match_ok_next = match_ok && byte_ok;
            state_next    = ST_READ;
          end
        end
      end
      ST_EMPTY: begin
        if (line_free) begin
          out_load   = 1'b1;
          ld_byte    = 8'h00;
          ld_last    = 1'b1;
          ld_hit     = len_eq;
          ld_empty   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    line_valid_next = out_load || (line_valid && line_stall);
  end

  `CLF_ASSERT(a_fill_range, fill <= FILL_MAX, "fill count past line capacity")
  `CLF_ASSERT(a_no_write_on_readout,
              (state == ST_READ || state == ST_LOAD) |-> !mem_ctl.wr_en,
              "store written during line readout")
  `CLF_ASSERT(a_empty_shape,
              line_valid && empty_line |-> last_of_line && (line_length == '0),
              "empty line result malformed")
  `CLF_ASSERT(a_hit_on_last, line_valid && keyword_hit |-> last_of_line,
              "keyword hit before end of line")
  `CLF_ASSERT(a_fill_clear_after_last, out_load && ld_last |=> fill == '0,
              "fill count not cleared after line")

endmodule

// File: hw/rtl/crlf_line_framer.sv
// first line byte: after the lf transaction come ST_READ, ST_LOAD, then the registered output
// empty line: after the lf transaction ST_EMPTY loads its single result into the output register
// throughput: one rx byte per cycle in idle; a held cr stored with a data byte adds ST_STORE2
// readout: ST_READ then ST_LOAD per line byte, for the store's registered read port; rx stalls
// reset: synchronous, clears sequencer, fill count and flags; keyword back to "Arrived", length 7
// store contents are not cleared; only entries below the fill count are ever read
module crlf_line_framer import clf_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  output logic                 line_valid,
  input  logic                 line_stall,
  output logic [7:0]           line_byte,
  output logic                 last_of_line,
  output logic [LEN_OUT_W-1:0] line_length,
  output logic                 keyword_hit,
  output logic                 empty_line,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TEXT_W-1:0]    cfg_data
);

  localparam int AW = $clog2(LINE_CAPACITY);

  logic [TEXT_W-1:0]   match_text;
  logic [KW_LEN_W-1:0] match_length;
  mem_ctl_t            mem_ctl;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_text   <= KW_RESET_TEXT;
      match_length <= KW_RESET_LEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MATCH_TEXT:   match_text   <= cfg_data;
        REG_MATCH_LENGTH: match_length <= cfg_data[KW_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  clf_ctrl #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .AW           (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .line_valid  (line_valid),
    .line_stall  (line_stall),
    .line_byte   (line_byte),
    .last_of_line(last_of_line),
    .line_length (line_length),
    .keyword_hit (keyword_hit),
    .empty_line  (empty_line),
    .match_text  (match_text),
    .match_length(match_length),
    .mem_ctl     (mem_ctl),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  clf_store #(
    .DEPTH(LINE_CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .ctl    (mem_ctl),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule
